/* design/vr2d_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// vr2d_pkg
// Shared widths, payload types and the CORDIC arctangent table for the
// 2D vector rotator.
// -----------------------------------------------------------------------------
package vr2d_pkg;

	// Field widths (fixed by the payload structs on the top-level ports)
	localparam int COORD_WIDTH = 24;
	localparam int PHASE_WIDTH = 16;

	// CORDIC datapath
	localparam int VR_STEPS  = 30;
	localparam int COEF_W    = 32;              // Q2.30 coefficient
	localparam int CXY_W     = 34;              // CORDIC x/y working width
	localparam int CZ_W      = 33;              // residual angle width
	localparam int CORDIC_LAT = VR_STEPS + 2;   // fold + steps + clamp registers

	// Gain-compensated 1.0 in Q2.30
	localparam logic [31:0] CORDIC_K = 32'd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_LUT [VR_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_in;
		logic signed [COORD_WIDTH-1:0] y_in;
		logic        [PHASE_WIDTH-1:0] phase;
	} vr2d_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_out;
		logic signed [COORD_WIDTH-1:0] y_out;
		logic                          clipped;
	} vr2d_out_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} vr2d_coord_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] cos;
		logic signed [COEF_W-1:0] sin;
	} vr2d_trig_t;

endpackage

/* design/vr2d_cordic.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// vr2d_cordic
// Pipelined rotation-mode CORDIC: binary phase in, clamped Q2.30 cosine and
// sine out, one CORDIC step per register stage.
// -----------------------------------------------------------------------------
module vr2d_cordic import vr2d_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic [PHASE_WIDTH-1:0] phase,
	output logic                   coef_valid,
	output vr2d_trig_t             coef
);

	localparam logic signed [CXY_W-1:0] ONE_X  = CXY_W'(64'sd1 <<< 30);
	localparam logic signed [CXY_W-1:0] MONE_X = -ONE_X;

	logic [VR_STEPS:0]              v_s;
	logic [VR_STEPS:0]              flip_s;
	logic signed [CXY_W-1:0]        cx_s [VR_STEPS+1];
	logic signed [CXY_W-1:0]        cy_s [VR_STEPS+1];
	logic signed [CZ_W-1:0]         cz_s [VR_STEPS+1];

	logic [31:0]                    ang;
	logic                           flip;
	logic [31:0]                    ang_f;
	logic signed [CXY_W-1:0]        xn;
	logic signed [CXY_W-1:0]        yn;
	logic signed [CXY_W-1:0]        xc;
	logic signed [CXY_W-1:0]        yc;

	// Fold the middle half turn onto the convergent range
	assign ang   = {phase, {(32-PHASE_WIDTH){1'b0}}};
	assign flip  = phase[PHASE_WIDTH-1] ^ phase[PHASE_WIDTH-2];
	assign ang_f = {ang[31] ^ flip, ang[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= CXY_W'(CORDIC_K);
		cy_s[0]   <= '0;
		cz_s[0]   <= CZ_W'($signed(ang_f));
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < VR_STEPS; i++) begin : g_step
		logic signed [CXY_W-1:0] dx;
		logic signed [CXY_W-1:0] dy;
		logic signed [CZ_W-1:0]  da;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign da = CZ_W'(ATAN_LUT[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (cz_s[i][CZ_W-1]) begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				cz_s[i+1] <= cz_s[i] + da;
			end else begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				cz_s[i+1] <= cz_s[i] - da;
			end
		end
	end

	// Undo the fold, then clamp to [-1, 1]
	assign xn = flip_s[VR_STEPS] ? -cx_s[VR_STEPS] : cx_s[VR_STEPS];
	assign yn = flip_s[VR_STEPS] ? -cy_s[VR_STEPS] : cy_s[VR_STEPS];

	always_comb begin
		if (xn > ONE_X) begin
			xc = ONE_X;
		end else if (xn < MONE_X) begin
			xc = MONE_X;
		end else begin
			xc = xn;
		end
		if (yn > ONE_X) begin
			yc = ONE_X;
		end else if (yn < MONE_X) begin
			yc = MONE_X;
		end else begin
			yc = yn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid <= 1'b0;
		end else begin
			coef_valid <= v_s[VR_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		coef.cos <= xc[COEF_W-1:0];
		coef.sin <= yc[COEF_W-1:0];
	end

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> (coef.cos <= COEF_W'(ONE_X)) && (coef.cos >= COEF_W'(MONE_X)) &&
			(coef.sin <= COEF_W'(ONE_X)) && (coef.sin >= COEF_W'(MONE_X)))
		else $error("coefficient outside [-1, 1]");

endmodule

/* design/vector_rotate_2d.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// vector_rotate_2d
// Fully pipelined counter-clockwise rotation of a fixed-point 2D point by a
// binary phase, with rounding and saturation of the result.
// -----------------------------------------------------------------------------
// Usage:
//   Drive sample (x_in, y_in, phase) and raise start. A transfer happens at
//   every rising edge where start is high and busy is low. busy never rises:
//   the pipeline takes one point per cycle, back to back, indefinitely.
//   The CORDIC (one step per stage, 30 steps, plus fold and clamp registers)
//   sets most of the depth; three more stages multiply, round and saturate.
//   Each result appears on result for exactly one cycle with done high,
//   in the order of transfer. The receiver cannot stall: a result not
//   taken in its cycle is gone. Sustained rate: one point per clock.
//   x_out = x*cos - y*sin, y_out = y*cos + x*sin, each rounded half up from
//   Q30 and clamped to the coordinate range; clipped flags any clamp.
//   Reset (arst_n low) clears every valid bit at once; points in flight are
//   dropped and no stale done strobe follows.
// -----------------------------------------------------------------------------
module vector_rotate_2d import vr2d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  vr2d_in_t  sample,
	output logic      done,
	output vr2d_out_t result
);

	localparam int PRD_W = COORD_WIDTH + COEF_W;   // one product
	localparam int SUM_W = PRD_W + 1;              // product sum
	localparam int RND_W = SUM_W - 30;             // after the Q30 shift
	localparam logic signed [SUM_W-1:0] RND_C = SUM_W'(64'sd1 <<< 29);
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic        take;
	logic        coef_valid;
	vr2d_trig_t  coef;

	vr2d_coord_t crd_s [CORDIC_LAT];

	logic                    v_s1, v_s2;
	logic signed [PRD_W-1:0] xc_s1, ys_s1, yc_s1, xs_s1;
	logic signed [RND_W-1:0] rx_s2, ry_s2;

	logic signed [COORD_WIDTH-1:0] xd, yd;
	logic signed [COEF_W-1:0]      cs, sn;
	logic signed [SUM_W-1:0]       ax, ay;
	logic                          ovf_x, ovf_y;

	// Never hold off a transfer
	assign busy = 1'b0;
	assign take = start & ~busy;

	vr2d_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (take),
		.phase     (sample.phase),
		.coef_valid(coef_valid),
		.coef      (coef)
	);

	// Delay the coordinates to meet their coefficients
	always_ff @(posedge clk) begin
		crd_s[0].x <= sample.x_in;
		crd_s[0].y <= sample.y_in;
		for (int i = 1; i < CORDIC_LAT; i++) begin
			crd_s[i] <= crd_s[i-1];
		end
	end

	assign xd = crd_s[CORDIC_LAT-1].x;
	assign yd = crd_s[CORDIC_LAT-1].y;
	assign cs = coef.cos;
	assign sn = coef.sin;

	// Stage 1: four products
	always_ff @(posedge clk) begin
		xc_s1 <= xd * cs;
		ys_s1 <= yd * sn;
		yc_s1 <= yd * cs;
		xs_s1 <= xd * sn;
	end

	// Stage 2: combine, round half up, drop the Q30 fraction
	assign ax = SUM_W'(xc_s1) - SUM_W'(ys_s1) + RND_C;
	assign ay = SUM_W'(yc_s1) + SUM_W'(xs_s1) + RND_C;

	always_ff @(posedge clk) begin
		rx_s2 <= ax[SUM_W-1:30];
		ry_s2 <= ay[SUM_W-1:30];
	end

	// Stage 3: saturate when the bits above the sign do not all agree with it
	assign ovf_x = ~((&rx_s2[RND_W-1:COORD_WIDTH-1]) | ~(|rx_s2[RND_W-1:COORD_WIDTH-1]));
	assign ovf_y = ~((&ry_s2[RND_W-1:COORD_WIDTH-1]) | ~(|ry_s2[RND_W-1:COORD_WIDTH-1]));

	always_ff @(posedge clk) begin
		result.x_out   <= ovf_x ? (rx_s2[RND_W-1] ? C_MIN : C_MAX) : rx_s2[COORD_WIDTH-1:0];
		result.y_out   <= ovf_y ? (ry_s2[RND_W-1] ? C_MIN : C_MAX) : ry_s2[COORD_WIDTH-1:0];
		result.clipped <= ovf_x | ovf_y;
	end

	// Advance the valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= coef_valid;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	a_done_follows_coef: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(coef_valid, 3))
		else $error("result strobe without a coefficient three cycles earlier");

	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.clipped) |-> (result.x_out == C_MAX || result.x_out == C_MIN ||
			result.y_out == C_MAX || result.y_out == C_MIN))
		else $error("clipped set but no output at a bound");

	a_noclip_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.clipped) |->
			(result.x_out == $past(rx_s2[COORD_WIDTH-1:0]) &&
			 result.y_out == $past(ry_s2[COORD_WIDTH-1:0])))
		else $error("unclipped output differs from rounded sum");

endmodule
